@@ rtl/concentric_disk_cosine_hemisphere_unit_assert.svh @@
// assertion macros shared by the concentric disk pipeline
// no dependencies
`ifndef CONCENTRIC_DISK_COSINE_HEMISPHERE_UNIT_ASSERT_SVH
`define CONCENTRIC_DISK_COSINE_HEMISPHERE_UNIT_ASSERT_SVH
// property that must hold once reset is released
`define CDH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication checked on the following edge
`define CDH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/cdh_pkg.sv @@
// shared constants, types and helpers for the concentric disk pipeline
// no dependencies
`timescale 1ns / 1ps
package cdh_pkg;
    localparam int unsigned INPUT_BITS_DEF    = 16;
    localparam int unsigned FRACTION_BITS_DEF = 15;
    // pi/4 in q31
    localparam logic [31:0] PI4_Q31 = 32'd1686629713;
    localparam logic [31:0] QONE    = 32'h8000_0000;
    // number of series terms in each evaluator
    localparam int unsigned SIN_TERMS = 5;
    localparam int unsigned COS_TERMS = 6;

    // per stage control and sign information
    typedef struct packed {
        logic aneg;
        logic bneg;
        logic first;
        logic zero;
    } cdh_ctl_t;

    // q31 product rounded half up
    function automatic logic [31:0] mul_q31(input logic [31:0] p, input logic [31:0] q);
        logic [63:0] prod;
        prod = 64'(p) * 64'(q) + 64'h4000_0000;
        return prod[62:31];
    endfunction

    // reciprocal of a series constant, ceil(2^(32+clog2 k) / k); elaboration only
    function automatic logic [32:0] recip_k(input logic [7:0] Kd);
        logic [63:0] n;
        n = 64'd1 << (32 + $clog2(Kd));
        return 33'((n + 64'(Kd) - 64'd1) / 64'(Kd));
    endfunction

    // shift that goes with recip_k
    function automatic int unsigned recip_sh(input logic [7:0] Kd);
        return 32 + $clog2(Kd);
    endfunction

    // rounded division by small series constant k, exact for v below 2^31
    // through the reciprocal m and shift sh from the two helpers above
    function automatic logic [31:0] div_k(input logic [31:0] v, input logic [7:0] Kd,
                                          input logic [32:0] m, input int unsigned sh);
        logic [31:0] s;
        logic [64:0] prod;
        s    = v + 32'(Kd >> 1);
        prod = 65'(s) * 65'(m);
        return 32'(prod >> sh);
    endfunction

    function automatic logic [7:0] sin_k(input int unsigned i);
        logic [7:0] r;
        unique case (i)
            0: r = 8'd110;
            1: r = 8'd72;
            2: r = 8'd42;
            3: r = 8'd20;
            default: r = 8'd6;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] cos_k(input int unsigned i);
        logic [7:0] r;
        unique case (i)
            0: r = 8'd132;
            1: r = 8'd90;
            2: r = 8'd56;
            3: r = 8'd30;
            4: r = 8'd12;
            default: r = 8'd2;
        endcase
        return r;
    endfunction
endpackage

@@ rtl/cdh_div.sv @@
// pipelined restoring divider: quotient = (num << 31) / den, num <= den
// depends on cdh_pkg
`timescale 1ns / 1ps
module cdh_div #(
    parameter int unsigned W = cdh_pkg::INPUT_BITS_DEF + 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        num,
    input  logic [W-1:0]        den,
    input  cdh_pkg::cdh_ctl_t   in_ctl,
    input  logic [W-1:0]        in_rmag,
    output logic                out_valid,
    output logic [31:0]         quot,
    output cdh_pkg::cdh_ctl_t   out_ctl,
    output logic [W-1:0]        out_rmag
);
    import cdh_pkg::*;
    // 32 quotient bits, four per stage
    localparam int unsigned STEPS = 4;
    localparam int unsigned NST   = 32 / STEPS;

    logic [W:0]     rem_reg  [NST];
    logic [W-1:0]   den_reg  [NST];
    logic [31:0]    q_reg    [NST];
    cdh_ctl_t       ctl_reg  [NST];
    logic [W-1:0]   rm_reg   [NST];
    logic [NST-1:0] v_reg;

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [W:0]   rem_in;
        logic [W-1:0] den_in;
        logic [31:0]  q_in;
        cdh_ctl_t     ctl_in;
        logic [W-1:0] rm_in;
        logic         v_in;
        logic [W:0]   rem_next;
        logic [31:0]  q_next;
        if (s == 0) begin : g_first
            // first quotient bit is 1 only when num == den
            assign rem_in = {1'b0, num};
            assign den_in = den;
            assign q_in   = '0;
            assign ctl_in = in_ctl;
            assign rm_in  = in_rmag;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign q_in   = q_reg[s-1];
            assign ctl_in = ctl_reg[s-1];
            assign rm_in  = rm_reg[s-1];
            assign v_in   = v_reg[s-1];
        end
        // four shift-subtract steps; first step of stage 0 does not shift
        always_comb
        begin
            logic [W+1:0] t;
            rem_next = rem_in;
            q_next   = q_in;
            for (int i = 0; i < STEPS; i++) begin
                if (s == 0 && i == 0)
                    t = {1'b0, rem_next};
                else
                    t = {rem_next, 1'b0};
                if (t >= {2'b00, den_in}) begin
                    t = t - {2'b00, den_in};
                    q_next = {q_next[30:0], 1'b1};
                end else begin
                    q_next = {q_next[30:0], 1'b0};
                end
                rem_next = t[W:0];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_in;
                q_reg[s]   <= q_next;
                ctl_reg[s] <= ctl_in;
                rm_reg[s]  <= rm_in;
            end
        end
    end

    // the schedule above yields bit 31 (num==den) then the 31 bits below it
    assign quot      = q_reg[NST-1];
    assign out_valid = v_reg[NST-1];
    assign out_ctl   = ctl_reg[NST-1];
    assign out_rmag  = rm_reg[NST-1];
endmodule

@@ rtl/cdh_trig.sv @@
// pipelined sin and cos Horner series in q31, two stages per term
// depends on cdh_pkg
`timescale 1ns / 1ps
module cdh_trig #(
    parameter int unsigned W = cdh_pkg::INPUT_BITS_DEF + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       t,
    input  cdh_pkg::cdh_ctl_t in_ctl,
    input  logic [W-1:0]      in_rmag,
    output logic              out_valid,
    output logic [31:0]       sin_val,
    output logic [31:0]       cos_val,
    output cdh_pkg::cdh_ctl_t out_ctl,
    output logic [W-1:0]      out_rmag
);
    import cdh_pkg::*;
    localparam int unsigned NST = 2 * COS_TERMS + 3;

    // stage 0: angle; stage 1: square; stages 2..13: product then division
    // for each term; stage 14: sin final
    logic [31:0]    p_reg  [NST];
    logic [31:0]    p2_reg [NST];
    logic [31:0]    hs_reg [NST];
    logic [31:0]    hc_reg [NST];
    cdh_ctl_t       ctl_reg[NST];
    logic [W-1:0]   rm_reg [NST];
    logic [NST-1:0] v_reg;

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [31:0] p_n, p2_n, hs_n, hc_n;
        cdh_ctl_t    c_in;
        logic [W-1:0] r_in;
        logic        v_in;
        if (s == 0) begin : g0
            logic [63:0] pr;
            assign pr   = 64'(t) * 64'(PI4_Q31) + 64'h4000_0000;
            assign p_n  = pr[62:31];
            assign p2_n = '0;
            assign hs_n = '0;
            assign hc_n = '0;
            assign c_in = in_ctl;
            assign r_in = in_rmag;
            assign v_in = in_valid;
        end else begin : gn
            assign c_in = ctl_reg[s-1];
            assign r_in = rm_reg[s-1];
            assign v_in = v_reg[s-1];
            assign p_n  = p_reg[s-1];
            if (s == 1) begin : g1
                assign p2_n = mul_q31(p_reg[0], p_reg[0]);
                assign hs_n = QONE;
                assign hc_n = QONE;
            end else if (s < NST - 1) begin : gt
                localparam int unsigned CI = (s - 2) / 2;
                assign p2_n = p2_reg[s-1];
                if ((s % 2) == 0) begin : gm
                    // product; first term uses p2 directly (h starts at one)
                    assign hc_n = (CI == 0) ? p2_reg[s-1]
                                            : mul_q31(p2_reg[s-1], hc_reg[s-1]);
                    if (CI < SIN_TERMS) begin : gs
                        assign hs_n = (CI == 0) ? p2_reg[s-1]
                                                : mul_q31(p2_reg[s-1], hs_reg[s-1]);
                    end else begin : gk
                        assign hs_n = hs_reg[s-1];
                    end
                end else begin : gd
                    // division by the series constant, then one minus it
                    localparam logic [7:0]  KC = cos_k(CI);
                    localparam logic [32:0] MC = recip_k(KC);
                    localparam int unsigned SC = recip_sh(KC);
                    assign hc_n = QONE - div_k(hc_reg[s-1], KC, MC, SC);
                    if (CI < SIN_TERMS) begin : gs
                        localparam logic [7:0]  KS = sin_k(CI);
                        localparam logic [32:0] MS = recip_k(KS);
                        localparam int unsigned SS = recip_sh(KS);
                        assign hs_n = QONE - div_k(hs_reg[s-1], KS, MS, SS);
                    end else begin : gk
                        assign hs_n = hs_reg[s-1];
                    end
                end
            end else begin : gl
                assign p2_n = p2_reg[s-1];
                assign hs_n = mul_q31(p_reg[s-1], hs_reg[s-1]);
                assign hc_n = hc_reg[s-1];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                p_reg[s]   <= p_n;
                p2_reg[s]  <= p2_n;
                hs_reg[s]  <= hs_n;
                hc_reg[s]  <= hc_n;
                ctl_reg[s] <= c_in;
                rm_reg[s]  <= r_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign sin_val   = hs_reg[NST-1];
    assign cos_val   = hc_reg[NST-1];
    assign out_ctl   = ctl_reg[NST-1];
    assign out_rmag  = rm_reg[NST-1];
endmodule

@@ rtl/cdh_sqrt.sv @@
// pipelined integer square root, two result bits per stage
// depends on cdh_pkg
`timescale 1ns / 1ps
module cdh_sqrt #(
    parameter int unsigned F = cdh_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*F+1:0]      radicand,
    input  logic signed [F+1:0] in_x,
    input  logic signed [F+1:0] in_y,
    output logic                out_valid,
    output logic [F:0]          root,
    output logic signed [F+1:0] out_x,
    output logic signed [F+1:0] out_y
);
    import cdh_pkg::*;
    // radicand is at most 2^(2F), root needs F+1 bits
    localparam int unsigned RB  = F + 1;
    localparam int unsigned NST = (RB + 1) / 2;
    localparam int unsigned VB  = 2 * RB;

    logic [VB-1:0]       v_reg [NST];
    logic [RB-1:0]       r_reg [NST];
    logic signed [F+1:0] x_reg [NST];
    logic signed [F+1:0] y_reg [NST];
    logic [NST-1:0]      vl_reg;

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [VB-1:0] v_in, v_n;
        logic [RB-1:0] r_in, r_n;
        logic signed [F+1:0] x_in, y_in;
        logic          vl_in;
        if (s == 0) begin : g0
            assign v_in  = VB'(radicand);
            assign r_in  = '0;
            assign x_in  = in_x;
            assign y_in  = in_y;
            assign vl_in = in_valid;
        end else begin : gn
            assign v_in  = v_reg[s-1];
            assign r_in  = r_reg[s-1];
            assign x_in  = x_reg[s-1];
            assign y_in  = y_reg[s-1];
            assign vl_in = vl_reg[s-1];
        end
        // digit-by-digit: result bit b = RB-1-2s and the next one down
        always_comb
        begin
            logic [VB+1:0] trial;
            v_n = v_in;
            r_n = r_in;
            for (int k = 0; k < 2; k++) begin
                if (2 * s + k < RB) begin
                    trial = (VB+2)'(r_n | (RB'(1) << (RB - 1 - (2 * s + k))))
                            * (VB+2)'(r_n | (RB'(1) << (RB - 1 - (2 * s + k))));
                    if (trial <= (VB+2)'(v_in))
                        r_n = r_n | (RB'(1) << (RB - 1 - (2 * s + k)));
                end
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vl_reg[s] <= 1'b0;
            else if (en)
                vl_reg[s] <= vl_in;
        end
        always_ff @(posedge clk)
        begin
            if (en) begin
                v_reg[s] <= v_n;
                r_reg[s] <= r_n;
                x_reg[s] <= x_in;
                y_reg[s] <= y_in;
            end
        end
    end

    assign out_valid = vl_reg[NST-1];
    assign root      = r_reg[NST-1];
    assign out_x     = x_reg[NST-1];
    assign out_y     = y_reg[NST-1];
endmodule

@@ rtl/concentric_disk_cosine_hemisphere_unit.sv @@
// concentric disk to cosine hemisphere mapping, top level
// pipeline: input and branch registers, divider, sin/cos series, scaling, sign, squares, square root
// throughput: one item per cycle; the whole pipeline advances unless the
// output register holds an item that is stalled
// reset: asynchronous active low, clears all valid bits, payload unreset
// depends on cdh_pkg, cdh_div, cdh_trig, cdh_sqrt and the assertion header
`timescale 1ns / 1ps
module concentric_disk_cosine_hemisphere_unit #(
    parameter int unsigned INPUT_BITS    = cdh_pkg::INPUT_BITS_DEF,
    parameter int unsigned FRACTION_BITS = cdh_pkg::FRACTION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [INPUT_BITS-1:0]          u_sample,
    input  logic [INPUT_BITS-1:0]          v_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [FRACTION_BITS+1:0] x_coord,
    output logic signed [FRACTION_BITS+1:0] y_coord,
    output logic [FRACTION_BITS:0]         z_height
);
    import cdh_pkg::*;
    `include "concentric_disk_cosine_hemisphere_unit_assert.svh"

    localparam int unsigned W  = INPUT_BITS + 1;
    localparam int unsigned F  = FRACTION_BITS;
    localparam int unsigned SH = INPUT_BITS + 31 - FRACTION_BITS;
    localparam int unsigned PW = W + 32;

    logic en;
    // whole pipeline moves together unless the output item is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // input stage: sign and magnitude
    logic [W-1:0] am_next, bm_next;
    logic         an_next, bn_next;
    logic [W:0]   u2, v2, half;
    assign half    = (W+1)'(1) << INPUT_BITS;
    assign u2      = {1'b0, u_sample, 1'b0};
    assign v2      = {1'b0, v_sample, 1'b0};
    assign an_next = u2 < half;
    assign bn_next = v2 < half;
    assign am_next = an_next ? W'(half - u2) : W'(u2 - half);
    assign bm_next = bn_next ? W'(half - v2) : W'(v2 - half);

    logic         s0_v_reg;
    logic [W-1:0] am_reg, bm_reg;
    logic         an_reg, bn_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_v_reg <= 1'b0;
        else if (en)
            s0_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            am_reg <= am_next;
            bm_reg <= bm_next;
            an_reg <= an_next;
            bn_reg <= bn_next;
        end
    end

    // branch select and operand order
    cdh_ctl_t     ctl_next, s1_ctl_reg;
    logic [W-1:0] num_next, den_next, s1_num_reg, s1_den_reg;
    logic         s1_v_reg;
    always_comb
    begin
        ctl_next.aneg  = an_reg;
        ctl_next.bneg  = bn_reg;
        ctl_next.first = am_reg > bm_reg;
        ctl_next.zero  = (am_reg == '0) && (bm_reg == '0);
        num_next = ctl_next.first ? bm_reg : am_reg;
        // a zero divisor only occurs when the result is forced to zero
        den_next = ctl_next.zero ? W'(1) : (ctl_next.first ? am_reg : bm_reg);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= s0_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_ctl_reg <= ctl_next;
            s1_num_reg <= num_next;
            s1_den_reg <= den_next;
        end
    end

    // ratio
    logic         d_v;
    logic [31:0]  d_q;
    cdh_ctl_t     d_ctl;
    logic [W-1:0] d_rm;
    cdh_div #(.W(W)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s1_v_reg), .num(s1_num_reg), .den(s1_den_reg),
        .in_ctl(s1_ctl_reg), .in_rmag(s1_den_reg),
        .out_valid(d_v), .quot(d_q), .out_ctl(d_ctl), .out_rmag(d_rm)
    );

    // sine and cosine
    logic         t_v;
    logic [31:0]  t_s, t_c;
    cdh_ctl_t     t_ctl;
    logic [W-1:0] t_rm;
    cdh_trig #(.W(W)) u_trig (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d_v), .t(d_q), .in_ctl(d_ctl), .in_rmag(d_rm),
        .out_valid(t_v), .sin_val(t_s), .cos_val(t_c), .out_ctl(t_ctl),
        .out_rmag(t_rm)
    );

    // radius scaling products
    logic [PW-1:0] px_next, py_next, px_reg, py_reg;
    cdh_ctl_t      s2_ctl_reg;
    logic          s2_v_reg;
    always_comb
    begin
        px_next = PW'(t_rm) * PW'(t_ctl.first ? t_c : t_s);
        py_next = PW'(t_rm) * PW'(t_ctl.first ? t_s : t_c);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (en)
            s2_v_reg <= t_v;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            px_reg     <= px_next;
            py_reg     <= py_next;
            s2_ctl_reg <= t_ctl;
        end
    end

    // round, saturate, apply sign
    function automatic logic [F:0] scale_out(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        r = (p + (PW'(1) << (SH - 1))) >> SH;
        if (r > (PW'(1) << F))
            return (F+1)'(1) << F;
        return r[F:0];
    endfunction

    logic [F:0]          xm_next, ym_next;
    logic [F:0]          xm_reg, ym_reg;
    logic signed [F+1:0] xs_reg, ys_reg;
    logic                s3_v_reg;
    always_comb
    begin
        xm_next = s2_ctl_reg.zero ? '0 : scale_out(px_reg);
        ym_next = s2_ctl_reg.zero ? '0 : scale_out(py_reg);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_v_reg <= 1'b0;
        else if (en)
            s3_v_reg <= s2_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            xm_reg <= xm_next;
            ym_reg <= ym_next;
            xs_reg <= s2_ctl_reg.aneg ? -$signed({1'b0, xm_next}) : $signed({1'b0, xm_next});
            ys_reg <= s2_ctl_reg.bneg ? -$signed({1'b0, ym_next}) : $signed({1'b0, ym_next});
        end
    end

    // squares
    logic [2*F+1:0] xx_reg, yy_reg;
    logic signed [F+1:0] xs4_reg, ys4_reg;
    logic           s4_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_v_reg <= 1'b0;
        else if (en)
            s4_v_reg <= s3_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en) begin
            xx_reg  <= (2*F+2)'(xm_reg) * (2*F+2)'(xm_reg);
            yy_reg  <= (2*F+2)'(ym_reg) * (2*F+2)'(ym_reg);
            xs4_reg <= xs_reg;
            ys4_reg <= ys_reg;
        end
    end

    // radicand, clamped at zero
    logic [2*F+2:0] sum;
    logic [2*F+1:0] rad;
    logic [2*F+2:0] one_sq;
    assign one_sq = (2*F+3)'(1) << (2 * F);
    assign sum    = (2*F+3)'(xx_reg) + (2*F+3)'(yy_reg);
    assign rad    = (sum >= one_sq) ? '0 : (2*F+2)'(one_sq - sum);

    logic q_v;
    logic [F:0] q_root;
    logic signed [F+1:0] q_x, q_y;
    cdh_sqrt #(.F(F)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s4_v_reg), .radicand(rad), .in_x(xs4_reg), .in_y(ys4_reg),
        .out_valid(q_v), .root(q_root), .out_x(q_x), .out_y(q_y)
    );

    assign out_valid = q_v;
    assign x_coord   = q_x;
    assign y_coord   = q_y;
    assign z_height  = q_root;

    `CDH_ASSERT(a_stall_only_when_held, !in_stall || (out_valid && out_stall), "stall without held item")
    `CDH_ASSERT_NEXT(a_held_stays, out_valid && out_stall, out_valid && $stable(z_height), "held item lost")
    `CDH_ASSERT(a_x_range, !out_valid || (x_coord <= $signed((F+2)'(1) << F) && x_coord >= -$signed((F+2)'(1) << F)), "x out of range")
    `CDH_ASSERT(a_z_range, !out_valid || (z_height <= ((F+1)'(1) << F)), "z out of range")
endmodule
